/* sv/abbr_pkg.sv */
// ----------------------------------------------------------------------------
// abbr_pkg: shared definitions for the ARGB row box blur
// Sizes, state encoding and the structs passed between front, queue and back.
// ----------------------------------------------------------------------------
package abbr_pkg;

	// Pixel and channel layout.
	localparam int PIX_W        = 32;
	localparam int CH_W         = 8;
	localparam int NUM_CH       = 4;

	// Radius register.
	localparam int RADIUS_W     = 6;
	localparam int RADIUS_RESET = 1;
	localparam int MAX_RADIUS   = 63;

	// Widest window and the row position, which saturates once it passes the window.
	localparam int WIN_MAX      = 2 * MAX_RADIUS + 1;
	localparam int POS_W        = $clog2(WIN_MAX + 1);
	localparam int POS_CAP      = WIN_MAX;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// The ring holds the widest window plus every pixel the front may run ahead:
	// for each queued command, a row start of up to MAX_RADIUS pixels and the
	// pixel that issued the command.
	localparam int RING_DEPTH   = 2 ** $clog2(WIN_MAX + QUEUE_DEPTH * (MAX_RADIUS + 1) + 1);
	localparam int RING_W       = $clog2(RING_DEPTH);

	// Signed row position of a window tap, which may lie before or past the row.
	localparam int Q_W          = POS_W + 2;

	// Window sum plus rounding term, and the window pixel count.
	localparam int SUM_W        = $clog2(255 * WIN_MAX + MAX_RADIUS + 1);
	localparam int CNT_W        = RADIUS_W + 1;

	// The divider finds one quotient bit per step.
	localparam int DIV_STEPS    = CH_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_DRAIN,
		BK_DIV,
		BK_OUT
	} back_state_t;

	// One command: the outputs one input pixel releases.
	typedef struct packed {
		logic [RING_W-1:0]   slot;
		logic [POS_W-1:0]    pos;
		logic [RADIUS_W-1:0] radius;
		logic [POS_W-1:0]    x_start;
		logic                flush;
	} blur_cmd_t;

	// Write port of the pixel ring.
	typedef struct packed {
		logic              en;
		logic [RING_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} ring_wr_t;

endpackage

/* sv/abbr_front.sv */
// ----------------------------------------------------------------------------
// abbr_front: input side of the row blur
// Stores each pixel in the ring, tracks the row position and issues commands.
// ----------------------------------------------------------------------------
module abbr_front import abbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                radius_we,
	input  logic [RADIUS_W-1:0] radius_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel_in,
	input  logic                row_end,
	output ring_wr_t            ring_wr,
	output logic                cmd_valid,
	output blur_cmd_t           cmd,
	input  logic                cmd_ready
);

	logic [RADIUS_W-1:0] radius_q;
	logic [POS_W-1:0]    pos_q;
	logic [RING_W-1:0]   wr_ptr_q;
	logic                accept;
	logic                reach;
	logic [POS_W-1:0]    radius_ext;

	// A pixel is taken whenever the queue can hold a command.
	assign in_ready   = cmd_ready;
	assign accept     = in_valid & in_ready;
	assign radius_ext = POS_W'(radius_q);
	assign reach      = (pos_q >= radius_ext);

	// Every accepted pixel goes into the ring.
	always_comb begin
		ring_wr.en   = accept;
		ring_wr.addr = wr_ptr_q;
		ring_wr.data = pixel_in;
	end

	// Classify the transaction: one output once the window is primed, all
	// remaining outputs of the row on its last pixel.
	always_comb begin
		cmd_valid     = accept & (row_end | reach);
		cmd.slot      = wr_ptr_q;
		cmd.pos       = pos_q;
		cmd.radius    = radius_q;
		cmd.x_start   = reach ? (pos_q - radius_ext) : '0;
		cmd.flush     = row_end;
	end

	// Radius register, row position and ring pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(RADIUS_RESET);
			pos_q    <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (radius_we) begin
				radius_q <= (radius_wdata > RADIUS_W'(MAX_RADIUS)) ?
					RADIUS_W'(MAX_RADIUS) : radius_wdata;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (row_end) begin
					pos_q <= '0;
				end else if (pos_q != POS_W'(POS_CAP)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

/* sv/abbr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// abbr_cmd_fifo: command queue between front and back
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module abbr_cmd_fifo import abbr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  blur_cmd_t push_data,
	output logic      not_full,
	input  logic      pop,
	output logic      not_empty,
	output blur_cmd_t pop_data
);

	blur_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign not_full  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push & not_full;
	assign do_pop    = pop & not_empty;
	assign pop_data  = entry_q[rd_q];

	// Entry storage; the depth is a power of two so the pointers wrap freely.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/abbr_back.sv */
// ----------------------------------------------------------------------------
// abbr_back: output side of the row blur
// Holds the pixel ring, sums each window tap by tap and divides per channel.
// ----------------------------------------------------------------------------
module abbr_back import abbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_wr_t         ring_wr,
	input  logic             cmd_valid,
	input  blur_cmd_t        cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic             row_done
);

	back_state_t         state_q;
	back_state_t         state_d;
	blur_cmd_t           cur_q;
	logic [POS_W-1:0]    x_q;
	logic [Q_W-1:0]      q_q;
	logic [PIX_W-1:0]    ring_mem [RING_DEPTH];
	logic [PIX_W-1:0]    rd_data_q;
	logic                rd_valid_q;
	logic [SUM_W-1:0]    sum_q [NUM_CH];
	logic [SUM_W-1:0]    rem_q [NUM_CH];
	logic [CH_W-1:0]     quo_q [NUM_CH];
	logic [SUM_W-1:0]    den_q;
	logic [STEP_W-1:0]   step_q;
	logic                rd_en;
	logic [RING_W-1:0]   rd_addr;
	logic [POS_W-1:0]    q_clamp;
	logic [POS_W-1:0]    tap_dist;
	logic                last_read;
	logic                last_x;
	logic [NUM_CH-1:0]   ge;
	logic [CNT_W-1:0]    count;

	// Window tap position clamped to the row, then turned into a ring slot.
	always_comb begin
		if (q_q[Q_W-1]) begin
			q_clamp = '0;
		end else if (q_q > Q_W'(cur_q.pos)) begin
			q_clamp = cur_q.pos;
		end else begin
			q_clamp = q_q[POS_W-1:0];
		end
		tap_dist = cur_q.pos - q_clamp;
		rd_addr  = cur_q.slot - RING_W'(tap_dist);
	end

	assign last_read = (q_q == (Q_W'(x_q) + Q_W'(cur_q.radius)));
	assign last_x    = cur_q.flush ? (x_q == cur_q.pos) : 1'b1;
	assign count     = {cur_q.radius, 1'b1};

	// One trial subtraction per channel and divider step.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			ge[c] = (rem_q[c] >= den_q);
		end
	end

	// Pixel ring: written by the front, read one tap per cycle.
	always_ff @(posedge clk) begin
		if (ring_wr.en) begin
			ring_mem[ring_wr.addr] <= ring_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (last_read) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (out_ready) begin
					state_d = last_x ? BK_IDLE : BK_READ;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd_pop   = 1'b0;
		rd_en     = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
			end
			BK_READ: begin
				rd_en = 1'b1;
			end
			BK_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// Result pixel, channel c at bits 8c and up.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			pixel_out[c*CH_W +: CH_W] = quo_q[c];
		end
		row_done = cur_q.flush & (x_q == cur_q.pos);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			rd_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= rd_en;
		end
	end

	// Datapath: tap walk, channel sums and the restoring divider.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cur_q <= cmd;
					x_q   <= cmd.x_start;
					q_q   <= Q_W'(cmd.x_start) - Q_W'(cmd.radius);
					for (int c = 0; c < NUM_CH; c++) begin
						sum_q[c] <= '0;
					end
				end
			end
			BK_READ: begin
				q_q <= q_q + 1'b1;
				if (rd_valid_q) begin
					for (int c = 0; c < NUM_CH; c++) begin
						sum_q[c] <= sum_q[c] + SUM_W'(rd_data_q[c*CH_W +: CH_W]);
					end
				end
			end
			BK_DRAIN: begin
				// Last tap plus the rounding term, which is the radius.
				for (int c = 0; c < NUM_CH; c++) begin
					rem_q[c] <= sum_q[c] + SUM_W'(rd_data_q[c*CH_W +: CH_W]) +
						SUM_W'(cur_q.radius);
				end
				den_q  <= SUM_W'(count) << (DIV_STEPS - 1);
				step_q <= '0;
			end
			BK_DIV: begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (ge[c]) begin
						rem_q[c] <= rem_q[c] - den_q;
					end
					quo_q[c] <= {quo_q[c][CH_W-2:0], ge[c]};
				end
				den_q  <= den_q >> 1;
				step_q <= step_q + 1'b1;
			end
			BK_OUT: begin
				if (out_ready && !last_x) begin
					x_q <= x_q + 1'b1;
					q_q <= Q_W'(x_q) + 1'b1 - Q_W'(cur_q.radius);
					for (int c = 0; c < NUM_CH; c++) begin
						sum_q[c] <= '0;
					end
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

endmodule

/* sv/argb_box_blur_row.sv */
// ----------------------------------------------------------------------------
// argb_box_blur_row: one-dimensional box blur of an ARGB pixel row
// Clamp-to-edge window of 2R+1 pixels with rounded per-channel averages.
// ----------------------------------------------------------------------------
// Pixels are accepted one per cycle as long as the four-entry command queue
// has room; the front stores each pixel in a 512-entry ring memory and queues
// the outputs it releases. The back takes a command from the queue while idle,
// then computes each of its output pixels in steps, holding for any output
// stall: ring reads of the 2R+1 window taps through the single read port, a
// drain step that adds the last tap and the rounding term, the bit-per-step
// divider working on the four channels side by side, and the output handshake.
// A non-last pixel releases at most one output, the last pixel of a row
// releases up to R+1, the final one marked with row_done.
// Radius writes are saturated to 63 and take effect on the next pixel.
module argb_box_blur_row import abbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                radius_we,
	input  logic [RADIUS_W-1:0] radius_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel_in,
	input  logic                row_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PIX_W-1:0]    pixel_out,
	output logic                row_done
);

	ring_wr_t  ring_wr;
	logic      push;
	blur_cmd_t push_cmd;
	logic      q_not_full;
	logic      q_not_empty;
	logic      pop;
	blur_cmd_t pop_cmd;

	// Input side: ring write and command generation.
	abbr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.radius_we    (radius_we),
		.radius_wdata (radius_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.row_end      (row_end),
		.ring_wr      (ring_wr),
		.cmd_valid    (push),
		.cmd          (push_cmd),
		.cmd_ready    (q_not_full)
	);

	// Command queue.
	abbr_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_cmd)
	);

	// Output side: window sums and averaging.
	abbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ring_wr   (ring_wr),
		.cmd_valid (q_not_empty),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.row_done  (row_done)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ARGB row box blur
// Streams rows of pixels through the valid/ready ports under several radius
// settings and idle patterns, and compares every blurred pixel and its
// row_done flag with a cycle-free predictor of the clamp-to-edge box blur.
// ----------------------------------------------------------------------------
module testbench;
	import abbr_pkg::*;

	// Predictor ring size, row position ceiling and run timing.
	localparam int WINDOW_SLOTS   = WIN_MAX;
	localparam int ROW_POS_LIMIT  = 8191;
	localparam int SETTLE_CYCLES  = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int STALL_CYCLES   = 400;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} row_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             done;
	} blurred_pixel_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                radius_we    = 1'b0;
	logic [RADIUS_W-1:0] radius_wdata = '0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [PIX_W-1:0]    pixel_in     = '0;
	logic                row_end      = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [PIX_W-1:0]    pixel_out;
	logic                row_done;

	// Pixels waiting to be offered, and blurred pixels still owed by the block.
	row_pixel_t     pixel_feed_q[$];
	blurred_pixel_t blurred_expect_q[$];
	row_pixel_t     feed_item;
	blurred_pixel_t owed_pixel;

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int stall_requests = 0;
	int stall_grants   = 0;
	int stall_left     = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// Predictor state: radius, pixel ring, first pixel of the row, position.
	logic [RADIUS_W-1:0] blur_radius;
	logic [PIX_W-1:0]    ring_pix [WINDOW_SLOTS];
	logic [PIX_W-1:0]    row_first;
	int                  row_pos;
	int                  ring_slot;

	argb_box_blur_row DUT (
		.clk,
		.arst_n,
		.radius_we,
		.radius_wdata,
		.in_valid,
		.in_ready,
		.pixel_in,
		.row_end,
		.out_valid,
		.out_ready,
		.pixel_out,
		.row_done
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Pixel of the row at position q, clamped to the row, where position cur sits
	// in ring slot cur_slot.
	function automatic logic [PIX_W-1:0] tap_pixel(int q, int cur, int cur_slot);
		int tap_dist;
		if (q <= 0)
			return row_first;
		if (q > cur)
			q = cur;
		tap_dist = (cur - q) % WINDOW_SLOTS;
		return ring_pix[(cur_slot + WINDOW_SLOTS - tap_dist) % WINDOW_SLOTS];
	endfunction

	// Rounded per-channel mean of the 2r+1 pixels centred on position x.
	function automatic logic [PIX_W-1:0] box_average(int x, int cur, int cur_slot, int r);
		int               count;
		int               avg;
		int               sum [NUM_CH];
		logic [PIX_W-1:0] p;
		logic [PIX_W-1:0] res;
		count = 2 * r + 1;
		res = '0;
		for (int c = 0; c < NUM_CH; c++)
			sum[c] = 0;
		for (int k = -r; k <= r; k++) begin
			p = tap_pixel(x + k, cur, cur_slot);
			for (int c = 0; c < NUM_CH; c++)
				sum[c] += p[CH_W*c +: CH_W];
		end
		for (int c = 0; c < NUM_CH; c++) begin
			avg = ((sum[c] & 'h7fff) + count / 2) / count;
			if (avg > 255)
				avg = 255;
			res[CH_W*c +: CH_W] = avg[CH_W-1:0];
		end
		return res;
	endfunction

	// Stores one accepted pixel and queues the blurred pixels it releases.
	function automatic void blur_predict_pixel(logic [PIX_W-1:0] pix, logic last);
		int             r;
		int             pos;
		int             slot;
		int             x;
		blurred_pixel_t e;
		r = blur_radius;
		pos = row_pos;
		slot = ring_slot % WINDOW_SLOTS;
		ring_pix[slot] = pix;
		if (pos == 0)
			row_first = pix;
		if (!last) begin
			if (pos >= r) begin
				e.pixel = box_average(pos - r, pos, slot, r);
				e.done = 1'b0;
				blurred_expect_q.insert(blurred_expect_q.size(), e);
			end
			ring_slot = (slot + 1) % WINDOW_SLOTS;
			if (row_pos < ROW_POS_LIMIT)
				row_pos++;
		end else begin
			// End of row: flush every remaining output and start a fresh row.
			x = (pos >= r) ? pos - r : 0;
			while (x <= pos) begin
				e.pixel = box_average(x, pos, slot, r);
				e.done = (x == pos);
				blurred_expect_q.insert(blurred_expect_q.size(), e);
				x++;
			end
			row_pos = 0;
			ring_slot = 0;
			row_first = '0;
		end
	endfunction

	// Sender: offers the next queued pixel and holds it until the transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_in <= '0;
			row_end <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pixel_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				feed_item = pixel_feed_q.pop_front();
				in_valid <= 1'b1;
				pixel_in <= feed_item.pixel;
				row_end <= feed_item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random ready, with a long hold-off whenever one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_grants <= 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_grants != stall_requests) begin
			out_ready <= 1'b0;
			stall_grants <= stall_requests;
			stall_left <= STALL_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on each input transaction, checks each output transaction
	// and watches for a stalled run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				blur_predict_pixel(pixel_in, row_end);
			if (out_valid && out_ready) begin
				if (blurred_expect_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: unexpected output pixel %h row_done %b",
							$realtime, pixel_out, row_done);
				end else begin
					owed_pixel = blurred_expect_q.pop_front();
					if (owed_pixel.pixel !== pixel_out || owed_pixel.done !== row_done) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: expected pixel %h row_done %b, got pixel %h row_done %b",
								$realtime, owed_pixel.pixel, owed_pixel.done,
								pixel_out, row_done);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	task automatic queue_pixel(logic [PIX_W-1:0] pix, logic last);
		row_pixel_t item;
		item.pixel = pix;
		item.last = last;
		pixel_feed_q.insert(pixel_feed_q.size(), item);
	endtask

	// Mostly random pixels, with black, white and saturated-channel mixes.
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] p;
		case ($urandom_range(9))
			0: p = '0;
			1: p = '1;
			2: begin
				for (int c = 0; c < NUM_CH; c++)
					p[CH_W*c +: CH_W] = $urandom_range(1) ? 8'hff : 8'h00;
			end
			default: p = $urandom;
		endcase
		return p;
	endfunction

	function automatic int pick_radius();
		case ($urandom_range(7))
			0: return 0;
			1: return MAX_RADIUS;
			2: return $urandom_range(MAX_RADIUS);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	// Queues count random pixels; closes_row flags the final one as the row end.
	task automatic queue_run(int count, bit closes_row);
		for (int i = 0; i < count; i++)
			queue_pixel(pick_pixel(), closes_row && (i == count - 1));
	endtask

	// Holds the sender until every owed pixel has arrived, then lets the
	// back end finish any window that releases no output.
	task automatic wait_all_done();
		do
			@(negedge clk);
		while (pixel_feed_q.size() != 0 || in_valid || blurred_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_radius(int value);
		@(posedge clk);
		radius_we <= 1'b1;
		radius_wdata <= value[RADIUS_W-1:0];
		@(posedge clk);
		radius_we <= 1'b0;
		blur_radius = (value > MAX_RADIUS) ? MAX_RADIUS : value;
		@(negedge clk);
	endtask

	// Random rows, some back to back, some with a radius change between or
	// within them.
	task automatic random_rows(int budget);
		int sent;
		int len;
		int cut;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(2) == 0) begin
				wait_all_done();
				set_radius(pick_radius());
			end
			len = ($urandom_range(19) == 0) ? $urandom_range(128, 160) : $urandom_range(1, 10);
			if (len > 10 && blur_radius > 4) begin
				wait_all_done();
				set_radius($urandom_range(4));
			end
			if (len > 2 && $urandom_range(9) == 0) begin
				cut = $urandom_range(1, len - 1);
				queue_run(cut, 1'b0);
				wait_all_done();
				set_radius(pick_radius());
				queue_run(len - cut, 1'b1);
			end else begin
				queue_run(len, 1'b1);
			end
			sent += len;
		end
	endtask

	initial begin
		blur_radius = RADIUS_RESET;
		row_pos = 0;
		ring_slot = 0;
		row_first = '0;
		for (int i = 0; i < WINDOW_SLOTS; i++)
			ring_pix[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset radius: channel extremes, then a row of a single pixel.
		queue_pixel(32'h0000_0000, 1'b0);
		queue_pixel(32'hffff_ffff, 1'b0);
		queue_pixel(32'h00ff_00ff, 1'b0);
		queue_pixel(32'hff00_ff00, 1'b1);
		queue_pixel(32'h8040_2010, 1'b1);
		wait_all_done();

		// Radius zero passes pixels straight through.
		set_radius(0);
		queue_pixel(32'hffff_ffff, 1'b0);
		queue_pixel(32'h0000_0000, 1'b0);
		queue_pixel(32'h1234_5678, 1'b1);
		wait_all_done();

		// Widest window on a short row of white pixels: largest channel sums,
		// and everything is released by the row end.
		set_radius(MAX_RADIUS);
		repeat (3) queue_pixel(32'hffff_ffff, 1'b0);
		queue_pixel(32'hffff_ffff, 1'b1);
		wait_all_done();

		// Radius grows, then shrinks, in the middle of a row.
		set_radius(2);
		queue_run(4, 1'b0);
		wait_all_done();
		set_radius(5);
		queue_run(3, 1'b1);
		wait_all_done();
		set_radius(3);
		queue_run(6, 1'b0);
		wait_all_done();
		set_radius(1);
		queue_run(3, 1'b1);
		wait_all_done();

		// A row longer than the widest window.
		queue_run(130, 1'b1);
		wait_all_done();

		// Random rows under three idle patterns.
		send_idle_pct = 14;
		recv_idle_pct = 68;
		random_rows(20);
		wait_all_done();
		send_idle_pct = 68;
		recv_idle_pct = 14;
		random_rows(20);
		wait_all_done();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Receiver holds off while a row keeps coming, so the input backs up.
		set_radius(2);
		stall_requests++;
		queue_run(40, 1'b1);
		wait_all_done();
		random_rows(20);

		wait_all_done();
		if (blurred_expect_q.size() != 0) begin
			$display("%0d expected output pixels never arrived", blurred_expect_q.size());
			mismatch_count += blurred_expect_q.size();
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
